// ===== hw/rtl/ocls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered card list store package
// Shared types, codes and the control program of the list sequencer.
// ----------------------------------------------------------------------------
package ocls_pkg;

  // Default number of list entries.
  localparam int unsigned DEFAULT_LIST_DEPTH = 64;

  // A card is stored as {rank, suit}.
  localparam int unsigned CardW = 6;

  // Operation codes of a command beat.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_APPEND_BACK = 3'd1,
    OP_POP_FRONT   = 3'd2,
    OP_REMOVE      = 3'd3,
    OP_COUNT_SUIT  = 3'd4
  } op_e;

  // Status codes of a result beat.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_e;

  // Command beat.
  typedef struct packed {
    logic [2:0] op;
    logic [3:0] card_rank;
    logic [1:0] card_suit;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [3:0] out_rank;
    logic [1:0] out_suit;
    logic [6:0] suit_count;
    logic [6:0] list_length;
    logic [1:0] status;
  } out_t;

  // Step counter of the sequencer.
  localparam int unsigned UpcW = 5;
  typedef logic [UpcW-1:0] upc_t;

  // Datapath actions, one per control word.
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_FINISH,
    ACT_SET_FULL,
    ACT_SET_EMPTY,
    ACT_SET_NOMATCH,
    ACT_PUSH_FRONT,
    ACT_APPEND_BACK,
    ACT_READ_HEAD,
    ACT_POP_TAKE,
    ACT_SCAN_SETUP,
    ACT_SCAN_MATCH,
    ACT_SCAN_COUNT,
    ACT_SHIFT,
    ACT_REMOVE_END
  } act_e;

  // Sequencing conditions.
  typedef enum logic [2:0] {
    JMP_NEXT,      // go to the following step
    JMP_GOTO,      // go to the target
    JMP_DISPATCH,  // wait for a command, then go to its routine
    JMP_FULL,      // target if the list is full, else next
    JMP_EMPTY,     // target if the list is empty, else next
    JMP_STREAM,    // hold until the entry stream drains, then target
    JMP_MATCH      // target on a match, next once drained, else hold
  } jmp_e;

  // One control word.
  typedef struct packed {
    act_e act;
    jmp_e jmp;
    upc_t target;
  } uword_t;

  // Step addresses.
  localparam upc_t UPC_IDLE         = 5'd0;
  localparam upc_t UPC_FIN          = 5'd1;
  localparam upc_t UPC_ERR_FULL     = 5'd2;
  localparam upc_t UPC_ERR_EMPTY    = 5'd3;
  localparam upc_t UPC_PUSH         = 5'd4;
  localparam upc_t UPC_PUSH_DO      = 5'd5;
  localparam upc_t UPC_APPEND       = 5'd6;
  localparam upc_t UPC_APPEND_DO    = 5'd7;
  localparam upc_t UPC_POP          = 5'd8;
  localparam upc_t UPC_POP_DO       = 5'd9;
  localparam upc_t UPC_REMOVE       = 5'd10;
  localparam upc_t UPC_REMOVE_SCAN  = 5'd11;
  localparam upc_t UPC_REMOVE_MISS  = 5'd12;
  localparam upc_t UPC_REMOVE_SHIFT = 5'd13;
  localparam upc_t UPC_REMOVE_END   = 5'd14;
  localparam upc_t UPC_COUNT        = 5'd15;
  localparam upc_t UPC_COUNT_SCAN   = 5'd16;

  // Control program.
  function automatic uword_t ucode_rom(input upc_t addr);
    uword_t w;
    unique case (addr)
      UPC_IDLE:         w = '{ACT_NOP,         JMP_DISPATCH, UPC_IDLE};
      UPC_FIN:          w = '{ACT_FINISH,      JMP_GOTO,     UPC_IDLE};
      UPC_ERR_FULL:     w = '{ACT_SET_FULL,    JMP_GOTO,     UPC_FIN};
      UPC_ERR_EMPTY:    w = '{ACT_SET_EMPTY,   JMP_GOTO,     UPC_FIN};
      UPC_PUSH:         w = '{ACT_NOP,         JMP_FULL,     UPC_ERR_FULL};
      UPC_PUSH_DO:      w = '{ACT_PUSH_FRONT,  JMP_GOTO,     UPC_FIN};
      UPC_APPEND:       w = '{ACT_NOP,         JMP_FULL,     UPC_ERR_FULL};
      UPC_APPEND_DO:    w = '{ACT_APPEND_BACK, JMP_GOTO,     UPC_FIN};
      UPC_POP:          w = '{ACT_READ_HEAD,   JMP_EMPTY,    UPC_ERR_EMPTY};
      UPC_POP_DO:       w = '{ACT_POP_TAKE,    JMP_GOTO,     UPC_FIN};
      UPC_REMOVE:       w = '{ACT_SCAN_SETUP,  JMP_NEXT,     UPC_IDLE};
      UPC_REMOVE_SCAN:  w = '{ACT_SCAN_MATCH,  JMP_MATCH,    UPC_REMOVE_SHIFT};
      UPC_REMOVE_MISS:  w = '{ACT_SET_NOMATCH, JMP_GOTO,     UPC_FIN};
      UPC_REMOVE_SHIFT: w = '{ACT_SHIFT,       JMP_STREAM,   UPC_REMOVE_END};
      UPC_REMOVE_END:   w = '{ACT_REMOVE_END,  JMP_GOTO,     UPC_FIN};
      UPC_COUNT:        w = '{ACT_SCAN_SETUP,  JMP_NEXT,     UPC_IDLE};
      UPC_COUNT_SCAN:   w = '{ACT_SCAN_COUNT,  JMP_STREAM,   UPC_FIN};
      default:          w = '{ACT_NOP,         JMP_GOTO,     UPC_IDLE};
    endcase
    return w;
  endfunction

  // Entry step of each operation; unknown codes just report.
  function automatic upc_t op_entry(input logic [2:0] op);
    upc_t e;
    unique case (op)
      OP_PUSH_FRONT:  e = UPC_PUSH;
      OP_APPEND_BACK: e = UPC_APPEND;
      OP_POP_FRONT:   e = UPC_POP;
      OP_REMOVE:      e = UPC_REMOVE;
      OP_COUNT_SUIT:  e = UPC_COUNT;
      default:        e = UPC_FIN;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ordered_card_list_store_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered card list store
// Bounded ordered list of cards with push, append, pop, remove and count.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (cmd_i: op, card_rank, card_suit) is taken at a rising
//   edge where start is high and busy is low. Exactly one result beat
//   follows on result_o, marked by done_o for a single cycle; the receiver
//   must take it then, it cannot be held off.
// Routines, from the accept edge to the cycle done_o is high:
//   push, append and pop check for full or empty, then act and finish;
//   unknown ops go straight to the finish step. count streams every
//   stored entry; remove streams the entries, and the scan to the
//   match and the move of the entries behind it share one pass.
//   busy drops in the cycle done_o is high, so the next command can be
//   taken there; one command is worked on at a time.
// The rate is set by the single read and write port of the card memory:
//   remove and count stream one stored entry per cycle through it.
// The list is a ring in the memory with a head pointer and an entry count.
// Reset empties the list at once; memory contents are never cleared.
// ----------------------------------------------------------------------------
module ordered_card_list_store_unit
  import ocls_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  cmd_i,
  output logic      done_o,
  output out_t      result_o
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam logic [AW-1:0] LastAddr = AW'(LIST_DEPTH - 1);
  localparam logic [CW-1:0] DepthCnt = CW'(LIST_DEPTH);

  // Ring pointer steps.
  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    return (a == LastAddr) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    return (a == '0) ? LastAddr : a - AW'(1);
  endfunction

  // Sequencer and datapath registers.
  upc_t             upc_q, upc_d;
  in_t              cmd_q, cmd_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [AW-1:0]    dptr_q, dptr_d;
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [CW-1:0]    remain_q, remain_d;
  logic             rvalid_q, rvalid_d;
  logic [CW-1:0]    scount_q, scount_d;
  logic [3:0]       rank_q, rank_d;
  logic [1:0]       suit_q, suit_d;
  logic [1:0]       status_q, status_d;
  logic             done_q, done_d;
  out_t             result_q, result_d;

  // Memory port signals.
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CardW-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [CardW-1:0] mem_rdata;

  // Decoded conditions.
  uword_t           uw;
  logic             accept;
  logic             full;
  logic             empty;
  logic             stream_act;
  logic             stream_go;
  logic             stream_done;
  logic             match;
  logic             suit_hit;
  logic [CardW-1:0] cmd_card;
  logic [CW:0]      tail_sum;
  logic [CW:0]      tail_wrap;
  logic [AW-1:0]    tail_addr;
  logic [CW+6:0]    len_ext;
  logic [CW+6:0]    scount_ext;

  ocls_ram #(
    .WIDTH (CardW),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Control word fetch and status decode.
  always_comb begin
    uw          = ucode_rom(upc_q);
    busy        = (upc_q != UPC_IDLE);
    accept      = start && !busy;
    full        = (count_q == DepthCnt);
    empty       = (count_q == '0);
    stream_act  = (uw.act == ACT_SCAN_MATCH) || (uw.act == ACT_SCAN_COUNT) ||
                  (uw.act == ACT_SHIFT);
    stream_go   = stream_act && (remain_q != '0);
    stream_done = !rvalid_q && (remain_q == '0);
    cmd_card    = {cmd_q.card_rank, cmd_q.card_suit};
    match       = rvalid_q && (mem_rdata == cmd_card);
    suit_hit    = rvalid_q && (mem_rdata[1:0] == cmd_q.card_suit);
    tail_sum    = (CW+1)'(head_q) + (CW+1)'(count_q);
    tail_wrap   = (tail_sum >= (CW+1)'(LIST_DEPTH)) ?
                  tail_sum - (CW+1)'(LIST_DEPTH) : tail_sum;
    tail_addr   = tail_wrap[AW-1:0];
    len_ext     = {7'd0, count_q};
    scount_ext  = {7'd0, scount_q};
  end

  // Next step of the sequencer.
  always_comb begin
    unique case (uw.jmp)
      JMP_NEXT:     upc_d = upc_q + upc_t'(1);
      JMP_GOTO:     upc_d = uw.target;
      JMP_DISPATCH: upc_d = accept ? op_entry(cmd_i.op) : upc_q;
      JMP_FULL:     upc_d = full ? uw.target : upc_q + upc_t'(1);
      JMP_EMPTY:    upc_d = empty ? uw.target : upc_q + upc_t'(1);
      JMP_STREAM:   upc_d = stream_done ? uw.target : upc_q;
      JMP_MATCH: begin
        if (match) begin
          upc_d = uw.target;
        end else if (stream_done) begin
          upc_d = upc_q + upc_t'(1);
        end else begin
          upc_d = upc_q;
        end
      end
      default:      upc_d = UPC_IDLE;
    endcase
  end

  // Datapath driven by the current control word.
  always_comb begin
    cmd_d     = cmd_q;
    head_d    = head_q;
    count_d   = count_q;
    wptr_d    = wptr_q;
    scount_d  = scount_q;
    rank_d    = rank_q;
    suit_d    = suit_q;
    status_d  = status_q;
    done_d    = 1'b0;
    result_d  = result_q;
    mem_we    = 1'b0;
    mem_waddr = wptr_q;
    mem_wdata = mem_rdata;
    mem_raddr = ptr_q;

    // Entry stream: one read per cycle in a streaming step while entries remain.
    dptr_d    = ptr_q;
    rvalid_d  = stream_go;
    ptr_d     = stream_go ? addr_inc(ptr_q) : ptr_q;
    remain_d  = stream_go ? remain_q - CW'(1) : remain_q;

    // A new command clears the result fields.
    if (accept) begin
      cmd_d    = cmd_i;
      rank_d   = '0;
      suit_d   = '0;
      scount_d = '0;
      status_d = ST_OK;
    end

    unique case (uw.act)
      ACT_NOP: begin
      end
      ACT_FINISH: begin
        done_d               = 1'b1;
        result_d.out_rank    = rank_q;
        result_d.out_suit    = suit_q;
        result_d.suit_count  = scount_ext[6:0];
        result_d.list_length = len_ext[6:0];
        result_d.status      = status_q;
      end
      ACT_SET_FULL:    status_d = ST_FULL;
      ACT_SET_EMPTY:   status_d = ST_EMPTY;
      ACT_SET_NOMATCH: status_d = ST_NOMATCH;
      ACT_PUSH_FRONT: begin
        mem_we    = 1'b1;
        mem_waddr = addr_dec(head_q);
        mem_wdata = cmd_card;
        head_d    = addr_dec(head_q);
        count_d   = count_q + CW'(1);
      end
      ACT_APPEND_BACK: begin
        mem_we    = 1'b1;
        mem_waddr = tail_addr;
        mem_wdata = cmd_card;
        count_d   = count_q + CW'(1);
      end
      ACT_READ_HEAD: mem_raddr = head_q;
      ACT_POP_TAKE: begin
        rank_d  = mem_rdata[5:2];
        suit_d  = mem_rdata[1:0];
        head_d  = addr_inc(head_q);
        count_d = count_q - CW'(1);
      end
      ACT_SCAN_SETUP: begin
        ptr_d    = head_q;
        remain_d = count_q;
      end
      ACT_SCAN_MATCH: begin
        // The gap opens where the match sits.
        if (match) begin
          wptr_d = dptr_q;
        end
      end
      ACT_SCAN_COUNT: begin
        if (suit_hit) begin
          scount_d = scount_q + CW'(1);
        end
      end
      ACT_SHIFT: begin
        // Each later entry moves up one place toward the front.
        if (rvalid_q) begin
          mem_we = 1'b1;
          wptr_d = addr_inc(wptr_q);
        end
      end
      ACT_REMOVE_END: count_d = count_q - CW'(1);
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q    <= UPC_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      remain_q <= '0;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      upc_q    <= upc_d;
      head_q   <= head_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      rvalid_q <= rvalid_d;
      done_q   <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    ptr_q    <= ptr_d;
    dptr_q   <= dptr_d;
    wptr_q   <= wptr_d;
    scount_q <= scount_d;
    rank_q   <= rank_d;
    suit_q   <= suit_d;
    status_q <= status_d;
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ocls_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ocls_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ocls_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered card list store checker
// Port-level properties of the command and result beats.
// ----------------------------------------------------------------------------
module ocls_checker
  import ocls_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input wire out_t result_o
);

  // A taken command keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy low right after a command beat was taken");

  // The result beat comes when the block is ready for the next command.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  // Result beats never come back to back.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two result beats in a row");

  // A failed operation carries no card and no count.
  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status != ST_OK)) |->
      (result_o.out_rank == '0 && result_o.out_suit == '0 &&
       result_o.suit_count == '0))
    else $error("error result carries card or count data");

endmodule

bind ordered_card_list_store_unit ocls_checker u_ocls_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire

// ===== tb/ordered_card_list_store_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered card list store checker
// Watches the command and result channels of the card list store. It keeps
// a shadow copy of the list, works out the result of every accepted command
// beat, and compares each result beat field by field with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module ordered_card_list_store_checker
  import ocls_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire logic  busy_i,
  input  wire in_t   cmd_i,
  input  wire logic  done_i,
  input  wire out_t  result_i,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_count_o
);

  // Shadow list: entry 0 is the front, only entries below shadow_len are live.
  logic [CardW-1:0] shadow_cards [LIST_DEPTH];
  int unsigned      shadow_len;

  // Predicted result beats in command order.
  out_t        predicted_results [$];
  out_t        oldest_result;
  int unsigned mismatch_total = 0;
  int unsigned outstanding_total = 0;
  int unsigned beats_seen = 0;

  assign mismatch_count_o    = mismatch_total;
  assign outstanding_count_o = outstanding_total;

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    mismatch_total++;
    $display("[%0t] mismatch on result beat %0d: %s", $realtime, beats_seen, msg);
  endtask

  // Apply one command to the shadow list and return the result it yields.
  function automatic out_t apply_list_op(input in_t c);
    out_t             r;
    logic [CardW-1:0] card;
    int               hit;
    int               i;
    r    = '0;
    card = {c.card_rank, c.card_suit};
    hit  = -1;
    case (c.op)
      OP_PUSH_FRONT: begin
        if (shadow_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > 0; i--) shadow_cards[i] = shadow_cards[i-1];
          shadow_cards[0] = card;
          shadow_len++;
        end
      end
      OP_APPEND_BACK: begin
        if (shadow_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_cards[shadow_len] = card;
          shadow_len++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_rank = shadow_cards[0][5:2];
          r.out_suit = shadow_cards[0][1:0];
          for (i = 0; i + 1 < shadow_len; i++) shadow_cards[i] = shadow_cards[i+1];
          shadow_len--;
        end
      end
      OP_REMOVE: begin
        // Only the first matching entry goes; the ones behind it move up.
        for (i = 0; i < shadow_len; i++) begin
          if (hit < 0 && shadow_cards[i] == card) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          for (i = hit; i + 1 < shadow_len; i++) shadow_cards[i] = shadow_cards[i+1];
          shadow_len--;
        end
      end
      OP_COUNT_SUIT: begin
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_cards[i][1:0] == c.card_suit) r.suit_count++;
        end
      end
      default: begin
        // Unused codes change nothing and only report the length.
      end
    endcase
    r.list_length = shadow_len[6:0];
    return r;
  endfunction

  // Check result beats first, then record the command beat of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_len = 0;
      predicted_results.delete();
      outstanding_total = 0;
    end else begin
      if (done_i) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("no command outstanding (list_length %0d)",
                                    result_i.list_length));
        end else begin
          oldest_result = predicted_results.pop_front();
          if (result_i.out_rank !== oldest_result.out_rank)
            report_mismatch($sformatf("out_rank %0d, expected %0d",
                                      result_i.out_rank, oldest_result.out_rank));
          if (result_i.out_suit !== oldest_result.out_suit)
            report_mismatch($sformatf("out_suit %0d, expected %0d",
                                      result_i.out_suit, oldest_result.out_suit));
          if (result_i.suit_count !== oldest_result.suit_count)
            report_mismatch($sformatf("suit_count %0d, expected %0d",
                                      result_i.suit_count, oldest_result.suit_count));
          if (result_i.list_length !== oldest_result.list_length)
            report_mismatch($sformatf("list_length %0d, expected %0d",
                                      result_i.list_length, oldest_result.list_length));
          if (result_i.status !== oldest_result.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result_i.status, oldest_result.status));
        end
        beats_seen++;
      end
      if (start_i && !busy_i) predicted_results.push_back(apply_list_op(cmd_i));
      outstanding_total = predicted_results.size();
    end
  end

endmodule

// ===== tb/ordered_card_list_store_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered card list store testbench
// Drives command beats into the card list store: a directed opening over the
// error cases and field extremes, then random episodes that fill the list to
// the top, drain it, churn a small set of cards through remove, and mix all
// op codes. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module ordered_card_list_store_unit_test;
  import ocls_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1350;
  localparam int unsigned QUIET_TAIL     = 150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 80;

  // Op codes that the block has no routine for.
  localparam logic [2:0] OpUnusedLo  = 3'd5;
  localparam logic [2:0] OpUnusedMid = 3'd6;
  localparam logic [2:0] OpUnusedHi  = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_t         cmd_beat;
  logic        done;
  out_t        result_beat;
  int unsigned mismatch_count;
  int unsigned outstanding_count;
  int unsigned cmds_sent = 0;
  int unsigned quiet_cycles = 0;

  ordered_card_list_store_unit #(
    .LIST_DEPTH(DEFAULT_LIST_DEPTH)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_beat),
    .done_o  (done),
    .result_o(result_beat)
  );

  ordered_card_list_store_checker #(
    .LIST_DEPTH(DEFAULT_LIST_DEPTH)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .cmd_i              (cmd_beat),
    .done_i             (done),
    .result_i           (result_beat),
    .mismatch_count_o   (mismatch_count),
    .outstanding_count_o(outstanding_count)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: the run ends if no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one command beat; busy only moves at rising edges, so it is looked
  // at on the falling edge before the edge that takes the beat.
  task automatic issue_cmd(input logic [2:0] op, input logic [3:0] rank,
                           input logic [1:0] suit, input bit gappy);
    int unsigned gap;
    start    <= 1'b1;
    cmd_beat <= '{op: op, card_rank: rank, card_suit: suit};
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    cmds_sent++;
    // Random idle burst, never in the closing stretch of the run.
    if (gappy && cmds_sent + QUIET_TAIL < ITEM_TARGET && $urandom_range(0, 3) == 0) begin
      gap      = $urandom_range(1, 15);
      start    <= 1'b0;
      cmd_beat <= in_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned mode;
    int unsigned run_len;
    int unsigned pick;
    int unsigned n;
    bit          gappy;
    logic [2:0]  op;
    logic [3:0]  rank;
    logic [1:0]  suit;

    rst_ni   <= 1'b0;
    start    <= 1'b0;
    cmd_beat <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: errors on an empty list, unused codes, field extremes.
    issue_cmd(OP_POP_FRONT, 4'd0, 2'd0, 1'b0);
    issue_cmd(OP_REMOVE, 4'd1, 2'd0, 1'b0);
    issue_cmd(OP_COUNT_SUIT, 4'd0, 2'd3, 1'b0);
    issue_cmd(OpUnusedLo, 4'd15, 2'd3, 1'b0);
    issue_cmd(OpUnusedMid, 4'd7, 2'd1, 1'b0);
    issue_cmd(OpUnusedHi, 4'd0, 2'd2, 1'b0);
    issue_cmd(OP_PUSH_FRONT, 4'd0, 2'd0, 1'b1);
    issue_cmd(OP_PUSH_FRONT, 4'd15, 2'd3, 1'b1);
    issue_cmd(OP_APPEND_BACK, 4'd13, 2'd2, 1'b1);
    issue_cmd(OP_APPEND_BACK, 4'd1, 2'd1, 1'b1);
    issue_cmd(OP_PUSH_FRONT, 4'd14, 2'd1, 1'b1);
    issue_cmd(OP_COUNT_SUIT, 4'd0, 2'd0, 1'b0);
    issue_cmd(OP_COUNT_SUIT, 4'd15, 2'd1, 1'b0);
    issue_cmd(OP_COUNT_SUIT, 4'd0, 2'd2, 1'b0);
    issue_cmd(OP_COUNT_SUIT, 4'd0, 2'd3, 1'b0);
    // Remove from the middle, the front and the back, then two near misses.
    issue_cmd(OP_REMOVE, 4'd0, 2'd0, 1'b1);
    issue_cmd(OP_REMOVE, 4'd14, 2'd1, 1'b1);
    issue_cmd(OP_REMOVE, 4'd1, 2'd1, 1'b1);
    issue_cmd(OP_REMOVE, 4'd15, 2'd2, 1'b0);
    issue_cmd(OP_REMOVE, 4'd13, 2'd3, 1'b0);
    issue_cmd(OP_POP_FRONT, 4'd5, 2'd2, 1'b0);
    issue_cmd(OP_POP_FRONT, 4'd0, 2'd0, 1'b0);
    issue_cmd(OP_POP_FRONT, 4'd0, 2'd0, 1'b0);

    // Random episodes: fill past full, drain past empty, remove churn on a
    // small card set, and fully random beats.
    while (cmds_sent < ITEM_TARGET) begin
      mode    = $urandom_range(0, 9);
      gappy   = $urandom_range(0, 1);
      run_len = (mode <= 1) ? $urandom_range(70, 90) : $urandom_range(30, 80);
      for (n = 0; n < run_len && cmds_sent < ITEM_TARGET; n++) begin
        pick = $urandom_range(0, 99);
        rank = $urandom_range(0, 15);
        suit = $urandom_range(0, 3);
        case (mode)
          0, 1: begin
            op = (pick < 45) ? OP_PUSH_FRONT :
                 (pick < 88) ? OP_APPEND_BACK :
                 (pick < 95) ? OP_COUNT_SUIT : OP_REMOVE;
          end
          2: begin
            op = (pick < 85) ? OP_POP_FRONT :
                 (pick < 95) ? OP_COUNT_SUIT : OP_REMOVE;
          end
          3, 4, 5: begin
            // Few distinct cards, so removes mostly find a match.
            rank = $urandom_range(1, 2);
            suit = $urandom_range(0, 1);
            op = (pick < 20) ? OP_PUSH_FRONT :
                 (pick < 35) ? OP_APPEND_BACK :
                 (pick < 70) ? OP_REMOVE :
                 (pick < 85) ? OP_COUNT_SUIT :
                 (pick < 97) ? OP_POP_FRONT : 3'($urandom_range(OpUnusedLo, OpUnusedHi));
          end
          default: begin
            op = 3'($urandom_range(0, 7));
          end
        endcase
        issue_cmd(op, rank, suit, gappy);
      end
    end
    start <= 1'b0;

    // Let every outstanding result beat arrive, then allow for stray ones.
    while (outstanding_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && outstanding_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
